// ===== hdl/set_assoc_lru_cache_model_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache model
// Immediate-style wrappers around concurrent assertions, removable at compile.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SALC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SALC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SALC_ASSERT_IMP(label, ante, cons)
`define SALC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hdl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Types and constants shared by the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;

	localparam logic [2:0] OC_HIT       = 3'd0;
	localparam logic [2:0] OC_MISS      = 3'd1;
	localparam logic [2:0] OC_MISS_EVICT = 3'd2;
	localparam logic [2:0] OC_MODIFY_ADD = 3'd2;

	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_OFF_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS     = 2'd2;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} rsp_t;

	typedef struct packed {
		logic        modify;
		logic [63:0] tag;
	} cls_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [1:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {31'd0, b};
		return s[32] ? CNT_MAX : s[31:0];
	endfunction
endpackage

// ===== hdl/salc_front.sv =====
// ----------------------------------------------------------------------------
// salc_front
// Accepts accesses, splits the address into set and tag, and queues them.
// ----------------------------------------------------------------------------
module salc_front #(
	parameter int SET_W = 8,
	parameter int QDEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  salc_pkg::req_t       request,
	input  logic [3:0]           set_index_bits,
	input  logic [3:0]           block_offset_bits,
	output logic                 q_valid,
	output salc_pkg::cls_t       q_cls,
	output logic [SET_W-1:0]     q_set,
	input  logic                 q_pop
);
	import salc_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	cls_t             cls_q [QDEPTH];
	logic [SET_W-1:0] set_q [QDEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	logic [3:0]       sbits;
	logic [63:0]      sh, mask;
	logic             push;

	always_comb begin
		sbits = (int'(set_index_bits) > SET_W) ? 4'(SET_W) : set_index_bits;
		sh = request.address >> block_offset_bits;
		mask = (64'd1 << sbits) - 64'd1;
	end

	assign busy = (cnt_q == (PW+1)'(QDEPTH));
	assign push = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_cls = cls_q[rp_q];
	assign q_set = set_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cls_q[wp_q].modify <= (request.operation == OP_MODIFY);
			cls_q[wp_q].tag <= sh >> sbits;
			set_q[wp_q] <= SET_W'(sh & mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			if (q_pop)
				rp_q <= (rp_q == PW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

	`include "set_assoc_lru_cache_model_defines.svh"
	`SALC_ASSERT_IMP(a_no_pop_empty, q_pop, q_valid)
	`SALC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (PW+1)'(QDEPTH))
	`SALC_ASSERT_NXT(a_push_fills, push && !q_pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

// ===== hdl/salc_back.sv =====
// ----------------------------------------------------------------------------
// salc_back
// Reads a set, compares tags and stamps, writes the set back, reports.
// ----------------------------------------------------------------------------
module salc_back #(
	parameter int SET_W = 8,
	parameter int WAYS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  salc_pkg::cls_t    q_cls,
	input  logic [SET_W-1:0]  q_set,
	output logic              q_pop,
	input  logic [3:0]        ways_in_use,
	output logic              done,
	output salc_pkg::rsp_t    result,
	output logic              idle
);
	import salc_pkg::*;

	localparam int NSETS = 1 << SET_W;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int VW = $clog2(NSETS) + 1;

	logic [64*WAYS-1:0] tag_mem [NSETS];
	logic [64*WAYS-1:0] stp_mem [NSETS];
	logic [WAYS-1:0]    vld_mem [NSETS];

	logic [VW-1:0]      clr_q;
	logic               busy_s1;
	cls_t               cls_s1;
	logic [SET_W-1:0]   set_s1;
	logic [64*WAYS-1:0] tag_s1, stp_s1;
	logic [WAYS-1:0]    vld_s1;
	logic [63:0]        acc_q;
	logic [31:0]        hit_q, miss_q, evc_q;

	logic               clearing;
	logic [WW:0]        ways;
	logic [WAYS-1:0]    use_m, hit_m;
	logic               hit, full;
	logic [WW-1:0]      hit_w, emp_w, vic_w, sel_w;
	logic [63:0]        least, acc_n;
	logic [64*WAYS-1:0] tag_n, stp_n;
	logic [WAYS-1:0]    vld_n;

	assign clearing = !clr_q[VW-1];
	assign q_pop = q_valid && !busy_s1 && !clearing;
	assign idle = !busy_s1 && !q_valid && !clearing;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tag_s1 <= tag_mem[q_set];
			stp_s1 <= stp_mem[q_set];
			vld_s1 <= vld_mem[q_set];
			cls_s1 <= q_cls;
			set_s1 <= q_set;
		end
		if (clearing)
			vld_mem[clr_q[SET_W-1:0]] <= '0;
		else if (busy_s1) begin
			tag_mem[set_s1] <= tag_n;
			stp_mem[set_s1] <= stp_n;
			vld_mem[set_s1] <= vld_n;
		end
	end

	always_comb begin
		ways = (ways_in_use == 4'd0) ? (WW+1)'(1) :
			((int'(ways_in_use) > WAYS) ? (WW+1)'(WAYS) : (WW+1)'(ways_in_use));
		acc_n = acc_q + 64'd1;
		hit = 1'b0;
		full = 1'b1;
		hit_w = '0;
		emp_w = '0;
		vic_w = '0;
		least = stp_s1[63:0];
		for (int w = 0; w < WAYS; w++) begin
			use_m[w] = ((WW+1)'(w) < ways);
			hit_m[w] = use_m[w] && vld_s1[w] && (tag_s1[64*w +: 64] == cls_s1.tag);
		end
		for (int w = WAYS-1; w >= 0; w--)
			if (hit_m[w]) begin
				hit = 1'b1;
				hit_w = WW'(w);
			end
		for (int w = 0; w < WAYS; w++)
			if (use_m[w] && !vld_s1[w]) begin
				full = 1'b0;
				emp_w = WW'(w);
			end
		for (int w = 1; w < WAYS; w++)
			if (use_m[w] && stp_s1[64*w +: 64] < least) begin
				least = stp_s1[64*w +: 64];
				vic_w = WW'(w);
			end
		sel_w = hit ? hit_w : (full ? vic_w : emp_w);
		tag_n = tag_s1;
		stp_n = stp_s1;
		vld_n = vld_s1;
		tag_n[64*sel_w +: 64] = cls_s1.tag;
		stp_n[64*sel_w +: 64] = acc_n;
		vld_n[sel_w] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			busy_s1 <= 1'b0;
			acc_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			evc_q <= '0;
			done <= 1'b0;
			result <= '0;
		end else begin
			if (clearing)
				clr_q <= clr_q + 1'b1;
			busy_s1 <= q_pop;
			done <= busy_s1;
			if (busy_s1) begin
				logic [31:0] h, m, e;
				logic [2:0]  oc;
				h = hit_q;
				m = miss_q;
				e = evc_q;
				if (hit) begin
					h = sat_inc(h, cls_s1.modify ? 2'd2 : 2'd1);
					oc = OC_HIT;
				end else begin
					m = sat_inc(m, 2'd1);
					oc = OC_MISS;
					if (full) begin
						e = sat_inc(e, 2'd1);
						oc = OC_MISS_EVICT;
					end
					if (cls_s1.modify) begin
						h = sat_inc(h, 2'd1);
						oc = oc + OC_MODIFY_ADD;
					end
				end
				acc_q <= acc_n;
				hit_q <= h;
				miss_q <= m;
				evc_q <= e;
				result <= '{outcome: oc, hit_total: h, miss_total: m, eviction_total: e};
			end
		end
	end

	`include "set_assoc_lru_cache_model_defines.svh"
	`SALC_ASSERT_NXT(a_one_result, busy_s1, done)
	`SALC_ASSERT_IMP(a_no_pop_clear, clearing, !q_pop)
	`SALC_ASSERT_IMP(a_outcome_range, done, result.outcome <= 3'd4)
endmodule

// ===== hdl/set_assoc_lru_cache_model.sv =====
// An accepted start goes through the queue, the back end's stage-1 registers, then done.
// The back end takes no access while it writes the last set back (read-then-write).
// A 2-entry queue lets start be taken while the back end works; busy flags it full.
// After reset the back end clears the valid bits of every set before taking
// its first access; results are not back-pressured.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache with LRU replacement and saturating hit/miss totals.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  salc_pkg::req_t request,
	output logic           done,
	output salc_pkg::rsp_t result,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [3:0]     cfg_data
);
	import salc_pkg::*;

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS + 1) - 1 : 0;
	localparam int SW = (SET_W > 0) ? SET_W : 1;

	logic [3:0]    sib_q, obb_q, way_q;
	logic          q_valid, q_pop, idle;
	cls_t          q_cls;
	logic [SW-1:0] q_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sib_q <= 4'd4;
			obb_q <= 4'd4;
			way_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_BITS: sib_q <= cfg_data;
				REG_OFF_BITS: obb_q <= cfg_data;
				REG_WAYS:     way_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	salc_front #(.SET_W(SW), .QDEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.set_index_bits((SET_W == 0) ? 4'd0 : sib_q), .block_offset_bits(obb_q),
		.q_valid(q_valid), .q_cls(q_cls), .q_set(q_set), .q_pop(q_pop)
	);

	salc_back #(.SET_W(SW), .WAYS(MAX_WAYS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cls(q_cls), .q_set(q_set),
		.q_pop(q_pop), .ways_in_use(way_q), .done(done), .result(result), .idle(idle)
	);

	`include "set_assoc_lru_cache_model_defines.svh"
	`SALC_ASSERT_IMP(a_cfg_idle, cfg_we, idle)
endmodule
